@@ hw/rtl/lhtg_pkg.sv @@
package lhtg_pkg;

  localparam int unsigned CntW     = 64;
  localparam int unsigned PctW     = 7;
  localparam int unsigned WaitW    = 24;
  localparam int unsigned LoadW    = 8;
  localparam int unsigned FieldW   = 5;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned DigW     = 4;
  localparam int unsigned StepW    = 4;

  // Each decimal digit of the quotient takes this many accumulate steps.
  localparam int unsigned DigitSteps = 10;

  localparam logic [PctW-1:0]  HighThrRst  = 7'd90;
  localparam logic [PctW-1:0]  LowThrRst   = 7'd10;
  localparam logic [PctW-1:0]  ThrPctRst   = 7'd50;
  localparam logic [WaitW-1:0] FullWaitRst = 24'd60000;
  localparam logic [WaitW-1:0] ThrWaitRst  = 24'd500;
  localparam logic [WaitW-1:0] MinWait     = 24'd100;

  localparam logic [LoadW-1:0]  LoadFull   = 8'd100;
  localparam logic [LoadW-1:0]  LoadFail   = 8'hFF;
  localparam logic [FieldW-1:0] FieldEn    = 5'h10;
  localparam logic [FieldW-1:0] FieldFull  = 5'h00;
  localparam logic [FieldW-1:0] DutyMax    = 5'd15;
  localparam logic [FieldW-1:0] DutyMin    = 5'd2;

  // floor(x/100) for x below 2048 as (x*1311) >> 17.
  localparam int unsigned RecipMul   = 1311;
  localparam int unsigned RecipShift = 17;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HIGH_THR  = 3'd0,
    CFG_LOW_THR   = 3'd1,
    CFG_THR_PCT   = 3'd2,
    CFG_FULL_WAIT = 3'd3,
    CFG_THR_WAIT  = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DT,
    ST_DI,
    ST_CMP,
    ST_TMR,
    ST_STEP,
    ST_ADD,
    ST_DONE
  } lhtg_state_e;

  typedef struct packed {
    logic [PctW-1:0]  high_thr;
    logic [PctW-1:0]  low_thr;
    logic [PctW-1:0]  thr_pct;
    logic [WaitW-1:0] full_wait;
    logic [WaitW-1:0] thr_wait;
  } cfg_t;

  typedef struct packed {
    logic                    valid;
    logic signed [LoadW-1:0] load;
  } load_res_t;

  function automatic logic [FieldW-1:0] field_for(input logic [PctW-1:0] pct);
    logic [10:0] x;
    logic [21:0] p;
    logic [FieldW-1:0] c;
    x = 11'(pct) * 11'd15;
    p = 22'(x) * 22'(RecipMul);
    c = 5'(p >> RecipShift) + 5'd1;
    if (c < DutyMin) begin
      c = DutyMin;
    end
    return (c <= DutyMax) ? (FieldEn | c) : FieldFull;
  endfunction

endpackage

@@ hw/rtl/lhtg_if.sv @@
interface lhtg_in_if;
  import lhtg_pkg::*;
  logic            valid;
  logic            ready;
  logic [CntW-1:0] time_count;
  logic [CntW-1:0] idle_count;
  logic            read_ok;

  modport source (output valid, time_count, idle_count, read_ok, input ready);
  modport sink (input valid, time_count, idle_count, read_ok, output ready);
endinterface

interface lhtg_out_if;
  import lhtg_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [LoadW-1:0] load_percent;
  logic                    is_throttled;
  logic [FieldW-1:0]       pm_field;
  logic                    pm_write;
  logic [WaitW-1:0]        next_wait_ms;

  modport source (output valid, load_percent, is_throttled, pm_field, pm_write,
                  next_wait_ms, input ready);
  modport sink (input valid, load_percent, is_throttled, pm_field, pm_write,
                next_wait_ms, output ready);
endinterface

@@ hw/rtl/lhtg_load_unit.sv @@
module lhtg_load_unit import lhtg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  lhtg_in_if.sink    in_i,
  output load_res_t  res_o,
  input  logic       res_ready_i
);

  lhtg_state_e state_q, state_d;
  logic primed_q, primed_d;
  logic phase_q, phase_d;
  logic [CntW-1:0] last_time_q, last_time_d, last_idle_q, last_idle_d;
  logic [CntW-1:0] cur_time_q, cur_time_d, cur_idle_q, cur_idle_d;
  logic [CntW-1:0] time_d_q, time_d_d, rem_q, rem_d, tmr_q, tmr_d, acc_q, acc_d;
  logic [DigW-1:0] dig_q, dig_d, hi_q, hi_d;
  logic [StepW-1:0] k_q, k_d;
  logic signed [LoadW-1:0] load_q, load_d;

  // The one shared 64-bit add/subtract unit.
  logic [CntW-1:0] op_a, op_b;
  logic            op_sub;
  logic [CntW:0]   sum;
  logic            borrow;

  logic [CntW-1:0] acc_next;
  logic [DigW-1:0] dig_next;
  logic            iter_done;
  logic [LoadW-1:0] quot;

  always_comb begin
    unique case (state_q)
      ST_DT: begin
        op_a = cur_time_q; op_b = last_time_q; op_sub = 1'b1;
      end
      ST_DI: begin
        op_a = cur_idle_q; op_b = last_idle_q; op_sub = 1'b1;
      end
      ST_CMP: begin
        op_a = rem_q; op_b = time_d_q; op_sub = 1'b1;
      end
      ST_TMR: begin
        op_a = time_d_q; op_b = rem_q; op_sub = 1'b1;
      end
      ST_STEP: begin
        op_a = acc_q; op_b = tmr_q; op_sub = 1'b1;
      end
      default: begin
        op_a = acc_q; op_b = rem_q; op_sub = 1'b0;
      end
    endcase
    sum    = {1'b0, op_a} + {1'b0, op_sub ? ~op_b : op_b} + {{CntW{1'b0}}, op_sub};
    borrow = op_sub & ~sum[CntW];
  end

  assign in_i.ready  = (state_q == ST_IDLE);
  assign res_o.valid = (state_q == ST_DONE);
  assign res_o.load  = load_q;

  always_comb begin
    state_d     = state_q;
    primed_d    = primed_q;
    phase_d     = phase_q;
    last_time_d = last_time_q;
    last_idle_d = last_idle_q;
    cur_time_d  = cur_time_q;
    cur_idle_d  = cur_idle_q;
    time_d_d    = time_d_q;
    rem_d       = rem_q;
    tmr_d       = tmr_q;
    acc_d       = acc_q;
    dig_d       = dig_q;
    hi_d        = hi_q;
    k_d         = k_q;
    load_d      = load_q;
    acc_next    = acc_q;
    dig_next    = dig_q;
    iter_done   = 1'b0;
    quot        = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          cur_time_d = in_i.time_count;
          cur_idle_d = in_i.idle_count;
          if (!in_i.read_ok) begin
            load_d  = $signed(LoadFail);
            state_d = ST_DONE;
          end else if (!primed_q) begin
            last_time_d = in_i.time_count;
            last_idle_d = in_i.idle_count;
            primed_d    = 1'b1;
            load_d      = '0;
            state_d     = ST_DONE;
          end else begin
            state_d = ST_DT;
          end
        end
      end
      ST_DT: begin
        time_d_d = sum[CntW-1:0];
        state_d  = ST_DI;
      end
      ST_DI: begin
        rem_d       = sum[CntW-1:0];
        last_time_d = cur_time_q;
        last_idle_d = cur_idle_q;
        state_d     = ST_CMP;
      end
      ST_CMP: begin
        // Idle delta not below time delta, a zero time delta included, reads as no load.
        if (borrow) begin
          phase_d = 1'b0;
          state_d = ST_TMR;
        end else begin
          load_d  = '0;
          state_d = ST_DONE;
        end
      end
      ST_TMR: begin
        tmr_d   = sum[CntW-1:0];
        acc_d   = '0;
        dig_d   = '0;
        k_d     = '0;
        state_d = ST_STEP;
      end
      ST_STEP: begin
        if (!borrow) begin
          acc_next  = sum[CntW-1:0];
          dig_next  = dig_q + DigW'(1);
          iter_done = 1'b1;
        end else begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        acc_next  = sum[CntW-1:0];
        iter_done = 1'b1;
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (iter_done) begin
      acc_d = acc_next;
      dig_d = dig_next;
      k_d   = k_q + StepW'(1);
      if (k_q == StepW'(DigitSteps - 1)) begin
        if (!phase_q) begin
          hi_d    = dig_next;
          rem_d   = acc_next;
          phase_d = 1'b1;
          state_d = ST_TMR;
        end else begin
          quot    = LoadW'(hi_q) * LoadW'(10) + LoadW'(dig_next);
          load_d  = $signed(LoadFull - quot);
          state_d = ST_DONE;
        end
      end else begin
        state_d = ST_STEP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      primed_q    <= 1'b0;
      phase_q     <= 1'b0;
      last_time_q <= '0;
      last_idle_q <= '0;
    end else begin
      state_q     <= state_d;
      primed_q    <= primed_d;
      phase_q     <= phase_d;
      last_time_q <= last_time_d;
      last_idle_q <= last_idle_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_time_q <= cur_time_d;
    cur_idle_q <= cur_idle_d;
    time_d_q   <= time_d_d;
    rem_q      <= rem_d;
    tmr_q      <= tmr_d;
    acc_q      <= acc_d;
    dig_q      <= dig_d;
    hi_q       <= hi_d;
    k_q        <= k_d;
    load_q     <= load_d;
  end

endmodule

@@ hw/rtl/lhtg_decide.sv @@
module lhtg_decide import lhtg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  load_res_t  res_i,
  output logic       res_ready_o,
  lhtg_out_if.source out_o
);

  logic valid_q, valid_d;
  logic thr_q, thr_d;
  logic seen_q, seen_d;
  logic signed [LoadW-1:0] load_q, load_d;
  logic [FieldW-1:0] field_q, field_d;
  logic write_q, write_d;
  logic [WaitW-1:0] wait_q, wait_d;

  logic take, neg, ge_high, le_low, release_thr, apply_thr, thr_mid;
  logic [WaitW-1:0] wait_sel;

  assign res_ready_o = !valid_q || out_o.ready;
  assign take        = res_i.valid && res_ready_o;

  always_comb begin
    neg     = res_i.load[LoadW-1];
    ge_high = !neg && (res_i.load[PctW-1:0] >= cfg_i.high_thr);
    le_low  = neg || (res_i.load[PctW-1:0] <= cfg_i.low_thr);

    // Release is checked before apply, so one beat can release and re-throttle.
    release_thr = seen_q && thr_q && ge_high;
    thr_mid     = thr_q && !release_thr;
    apply_thr   = seen_q && !thr_mid && le_low;

    valid_d = valid_q;
    thr_d   = thr_q;
    seen_d  = seen_q;
    load_d  = load_q;
    field_d = field_q;
    write_d = write_q;
    wait_d  = wait_q;
    wait_sel = '0;

    if (out_o.ready) begin
      valid_d = 1'b0;
    end
    if (take) begin
      thr_d    = thr_mid || apply_thr;
      seen_d   = 1'b1;
      valid_d  = 1'b1;
      load_d   = res_i.load;
      write_d  = release_thr || apply_thr;
      field_d  = thr_d ? field_for(cfg_i.thr_pct) : FieldFull;
      wait_sel = thr_d ? cfg_i.thr_wait : cfg_i.full_wait;
      wait_d   = (wait_sel < MinWait) ? MinWait : wait_sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      thr_q   <= 1'b0;
      seen_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      thr_q   <= thr_d;
      seen_q  <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    load_q  <= load_d;
    field_q <= field_d;
    write_q <= write_d;
    wait_q  <= wait_d;
  end

  assign out_o.valid        = valid_q;
  assign out_o.load_percent = load_q;
  assign out_o.is_throttled = thr_q;
  assign out_o.pm_field     = field_q;
  assign out_o.pm_write     = write_q;
  assign out_o.next_wait_ms = wait_q;

endmodule

@@ hw/rtl/load_hysteresis_throttle_governor.sv @@
// Channel   Direction  Beat contents
// in_i      sink       time_count, idle_count, read_ok
// out_o     source     load_percent, is_throttled, pm_field, pm_write, next_wait_ms
// cfg       write      cfg_we_i, cfg_idx_i, cfg_wdata_i (five registers)
//
// A failed read or the first good read goes straight to the result. A measured sample
// runs the two 10-step decimal digit loops on the one shared 64-bit add/subtract unit
// unless it reads as no load. Input is taken only while the sequencer is idle.
// The output register holds a finished beat while the next sample is worked on.
// Reset (asynchronous, active low) loads the register defaults and clears state.
module load_hysteresis_throttle_governor import lhtg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  lhtg_in_if.sink             in_i,
  lhtg_out_if.source          out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t      cfg_q;
  load_res_t res;
  logic      res_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.high_thr  <= HighThrRst;
      cfg_q.low_thr   <= LowThrRst;
      cfg_q.thr_pct   <= ThrPctRst;
      cfg_q.full_wait <= FullWaitRst;
      cfg_q.thr_wait  <= ThrWaitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_HIGH_THR:  cfg_q.high_thr  <= cfg_wdata_i[PctW-1:0];
        CFG_LOW_THR:   cfg_q.low_thr   <= cfg_wdata_i[PctW-1:0];
        CFG_THR_PCT:   cfg_q.thr_pct   <= cfg_wdata_i[PctW-1:0];
        CFG_FULL_WAIT: cfg_q.full_wait <= cfg_wdata_i[WaitW-1:0];
        CFG_THR_WAIT:  cfg_q.thr_wait  <= cfg_wdata_i[WaitW-1:0];
        default: ;
      endcase
    end
  end

  lhtg_load_unit u_load (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  lhtg_decide u_decide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .res_i       (res),
    .res_ready_o (res_ready),
    .out_o       (out_o)
  );

endmodule

@@ tb/tb_load_hysteresis_throttle_governor.sv @@
module tb_load_hysteresis_throttle_governor;
  timeunit 1ns;
  timeprecision 1ps;

  import lhtg_pkg::*;

  localparam logic [WaitW-1:0] MinWaitMs = 24'd100;
  localparam int DutyFloor = 2;
  localparam int DutyCeil = 15;
  localparam int PhaseCount = 12;
  localparam int ItemsPerPhase = 110;
  localparam int SettleCycles = 60;
  localparam int MaxPrinted = 40;
  localparam int ProdW = CntW + 8;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = CfgIdxW'(CFG_THR_WAIT) + 1'b1;

  typedef struct packed {
    logic [CntW-1:0] time_count;
    logic [CntW-1:0] idle_count;
    logic            read_ok;
  } sample_t;

  typedef struct packed {
    logic signed [LoadW-1:0] load;
    logic                    throttled;
    logic [FieldW-1:0]       field;
    logic                    write;
    logic [WaitW-1:0]        wait_ms;
  } decision_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_MASK, RX_RUNS} rx_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  lhtg_in_if  in_if ();
  lhtg_out_if out_if ();

  load_hysteresis_throttle_governor uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Governor state as the block should hold it.
  cfg_t            gov_cfg;
  logic [CntW-1:0] gov_time;
  logic [CntW-1:0] gov_idle;
  logic            gov_primed;
  logic            gov_live;
  logic            gov_throttled;

  // Counters as the stimulus generator last left them.
  logic [CntW-1:0] gen_time;
  logic [CntW-1:0] gen_idle;

  sample_t   sample_q[$];
  decision_t decision_q[$];

  int err_cnt = 0;
  int n_samples = 0;
  int n_failed = 0;
  int n_results = 0;
  int n_writes = 0;
  int n_drains = 0;
  int n_settings = 1;

  logic      in_taken = 1'b0;
  sample_t   drv_sample;
  int        burst_left = 1;
  int        gap_left = 0;
  int        burst_cnt = 0;
  logic      drain_hold = 1'b0;
  decision_t want;
  decision_t fresh;

  rx_mode_e  rx_mode = RX_OPEN;
  int        rx_age = 0;
  int        run_left = 0;
  logic      run_ready = 1'b0;
  logic [7:0] ready_mask = 8'hFF;
  logic [2:0] pat_idx = '0;
  logic      rdy_next;

  function automatic decision_t predict_decision(sample_t s);
    logic [CntW-1:0]   dt;
    logic [CntW-1:0]   di;
    logic [CntW+6:0]   quot;
    int                ld;
    int                code;
    decision_t         d;
    dt = s.time_count - gov_time;
    di = s.idle_count - gov_idle;
    d.write = 1'b0;
    if (!s.read_ok) begin
      ld = -1;
    end else begin
      if (!gov_primed || dt == '0 || di >= dt) begin
        ld = 0;
      end else begin
        quot = ({7'd0, di} * 71'd100) / {7'd0, dt};
        ld = 100 - int'(quot);
      end
      gov_primed = 1'b1;
      gov_time = s.time_count;
      gov_idle = s.idle_count;
    end
    // The very first beat after reset is only a priming call.
    if (gov_live) begin
      if (gov_throttled && ld >= int'(gov_cfg.high_thr)) begin
        gov_throttled = 1'b0;
        d.write = 1'b1;
      end
      if (!gov_throttled && ld <= int'(gov_cfg.low_thr)) begin
        gov_throttled = 1'b1;
        d.write = 1'b1;
      end
    end
    gov_live = 1'b1;
    code = int'(gov_cfg.thr_pct) * 15 / 100 + 1;
    if (code < DutyFloor) begin
      code = DutyFloor;
    end
    d.field = (gov_throttled && code <= DutyCeil) ? (FieldEn | FieldW'(code)) : FieldFull;
    d.wait_ms = gov_throttled ? gov_cfg.thr_wait : gov_cfg.full_wait;
    if (d.wait_ms < MinWaitMs) begin
      d.wait_ms = MinWaitMs;
    end
    d.load = LoadW'(ld);
    d.throttled = gov_throttled;
    return d;
  endfunction

  function automatic void apply_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    case (idx)
      CFG_HIGH_THR:  gov_cfg.high_thr = data[PctW-1:0];
      CFG_LOW_THR:   gov_cfg.low_thr = data[PctW-1:0];
      CFG_THR_PCT:   gov_cfg.thr_pct = data[PctW-1:0];
      CFG_FULL_WAIT: gov_cfg.full_wait = data[WaitW-1:0];
      CFG_THR_WAIT:  gov_cfg.thr_wait = data[WaitW-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [CntW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [CntW-1:0] pick_span();
    case ($urandom_range(0, 3))
      0: return CntW'($urandom_range(1, 10));
      1: return CntW'($urandom_range(1, 65535));
      2: return CntW'($urandom);
      default: return rand64();
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_cnt < MaxPrinted) begin
      $display("[%0t] MISMATCH %s", $realtime, msg);
    end
    err_cnt++;
  endtask

  task automatic check_field(input string name, input logic [WaitW-1:0] got,
                             input logic [WaitW-1:0] exp_v);
    if (got !== exp_v) begin
      report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                n_results, name, got, exp_v));
    end
  endtask

  task automatic queue_sample(input logic [CntW-1:0] t, input logic [CntW-1:0] i,
                              input logic ok);
    sample_t s;
    s.time_count = t;
    s.idle_count = i;
    s.read_ok = ok;
    sample_q.push_back(s);
    if (ok) begin
      gen_time = t;
      gen_idle = i;
    end
  endtask

  task automatic queue_delta(input logic [CntW-1:0] dt, input logic [CntW-1:0] di);
    queue_sample(gen_time + dt, gen_idle + di, 1'b1);
  endtask

  // Mostly well-formed counter progressions aimed at loads near the thresholds.
  task automatic queue_random_sample();
    int              pick;
    int              target;
    logic [CntW-1:0] dt;
    logic [ProdW-1:0] prod;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      queue_sample(rand64(), rand64(), 1'b0);
    end else if (pick < 11) begin
      queue_delta('0, ($urandom_range(0, 1) != 0) ? rand64() : pick_span());
    end else if (pick < 14) begin
      dt = pick_span();
      queue_delta(dt, dt + CntW'($urandom_range(0, 3)));
    end else if (pick < 19) begin
      queue_sample(rand64(), rand64(), 1'b1);
    end else if (pick < 22) begin
      queue_sample(~CntW'($urandom_range(0, 2000)), ~CntW'($urandom_range(0, 2000)), 1'b1);
    end else begin
      case ($urandom_range(0, 2))
        0: target = int'(gov_cfg.high_thr);
        1: target = int'(gov_cfg.low_thr);
        default: target = $urandom_range(0, 100);
      endcase
      target = target + int'($urandom_range(0, 2)) - 1;
      if (target < 0) begin
        target = 0;
      end
      if (target > 100) begin
        target = 100;
      end
      dt = pick_span();
      prod = {8'd0, dt} * ProdW'(100 - target);
      queue_delta(dt, CntW'(prod / 100));
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    apply_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic program_phase(input int phase);
    logic [PctW-1:0]     hi;
    logic [PctW-1:0]     lo;
    logic [PctW-1:0]     pct;
    logic [WaitW-1:0]    fw;
    logic [WaitW-1:0]    tw;
    logic [CfgDataW-1:0] pad;
    case (phase)
      1: begin
        hi = 7'd100; lo = 7'd0; pct = 7'd0; fw = '1; tw = MinWaitMs;
      end
      2: begin
        // High below low: a release and a re-throttle can fire on one beat.
        hi = 7'd0; lo = 7'd100; pct = 7'd99; fw = '0; tw = 24'd99;
      end
      3: begin
        hi = '1; lo = '1; pct = '1; fw = MinWaitMs; tw = '1;
      end
      4: begin
        hi = 7'd1; lo = 7'd0; pct = 7'd6; fw = 24'd99; tw = '0;
      end
      5: begin
        hi = 7'd50; lo = 7'd49; pct = 7'd7; fw = WaitW'($urandom); tw = WaitW'($urandom);
      end
      6: begin
        hi = 7'd100; lo = 7'd100; pct = 7'd100; fw = 24'd101; tw = 24'd100;
      end
      default: begin
        lo = PctW'($urandom_range(0, 60));
        hi = PctW'($urandom_range(int'(lo) + 1, 100));
        if ($urandom_range(0, 4) == 0) begin
          lo = PctW'($urandom);
          hi = PctW'($urandom);
        end
        pct = ($urandom_range(0, 5) == 0) ? PctW'($urandom) : PctW'($urandom_range(0, 99));
        fw = ($urandom_range(0, 3) == 0) ? WaitW'($urandom_range(0, 200)) : WaitW'($urandom);
        tw = ($urandom_range(0, 3) == 0) ? WaitW'($urandom_range(0, 200)) : WaitW'($urandom);
      end
    endcase
    // Every third setting puts junk above the narrow registers' widths.
    pad = (phase % 3 == 0) ? CfgDataW'($urandom) : '0;
    write_reg(CFG_HIGH_THR, {pad[CfgDataW-1:PctW], hi});
    write_reg(CFG_LOW_THR, {pad[CfgDataW-1:PctW], lo});
    write_reg(CFG_THR_PCT, {pad[CfgDataW-1:PctW], pct});
    write_reg(CFG_FULL_WAIT, fw);
    write_reg(CFG_THR_WAIT, tw);
    write_reg(CfgIdxW'($urandom_range(int'(CfgIdxSpare), (1 << CfgIdxW) - 1)),
              CfgDataW'($urandom));
    n_settings++;
  endtask

  task automatic wait_for_idle();
    do begin
      @(posedge clk_i);
    end while (sample_q.size() != 0 || in_if.valid || decision_q.size() != 0);
  endtask

  // Sender: bursts of random length, random gaps, and now and then a full drain.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      if (drain_hold) begin
        if (decision_q.size() == 0) begin
          drain_hold = 1'b0;
        end
        in_if.valid <= 1'b0;
      end else if (gap_left != 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (sample_q.size() == 0) begin
        in_if.valid <= 1'b0;
      end else begin
        drv_sample = sample_q.pop_front();
        in_if.valid <= 1'b1;
        in_if.time_count <= drv_sample.time_count;
        in_if.idle_count <= drv_sample.idle_count;
        in_if.read_ok <= drv_sample.read_ok;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_cnt++;
          burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
          if (burst_cnt == 3 || $urandom_range(0, 7) == 0) begin
            drain_hold = 1'b1;
            n_drains++;
          end
        end
      end
    end
  end

  // Receiver: its own stall pattern, re-chosen after a run of random length.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (rx_age == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        ready_mask = 8'($urandom) | 8'h01;
        rx_age = $urandom_range(50, 400);
      end
      rx_age--;
      pat_idx++;
      case (rx_mode)
        RX_OPEN: rdy_next = 1'b1;
        RX_COIN: rdy_next = ($urandom_range(0, 3) != 0);
        RX_MASK: rdy_next = ready_mask[pat_idx];
        default: begin
          if (run_left == 0) begin
            run_ready = !run_ready;
            run_left = run_ready ? $urandom_range(1, 8) : $urandom_range(1, 40);
          end
          run_left--;
          rdy_next = run_ready;
        end
      endcase
      out_if.ready <= rdy_next;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (decision_q.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing outstanding (load 0x%0h)",
                                    out_if.load_percent));
        end else begin
          want = decision_q.pop_front();
          check_field("load_percent", {16'd0, out_if.load_percent}, {16'd0, want.load});
          check_field("is_throttled", {23'd0, out_if.is_throttled}, {23'd0, want.throttled});
          check_field("pm_field", {19'd0, out_if.pm_field}, {19'd0, want.field});
          check_field("pm_write", {23'd0, out_if.pm_write}, {23'd0, want.write});
          check_field("next_wait_ms", out_if.next_wait_ms, want.wait_ms);
          if (want.write) begin
            n_writes++;
          end
          n_results++;
        end
      end
      if (in_if.valid && in_if.ready) begin
        fresh = predict_decision({in_if.time_count, in_if.idle_count, in_if.read_ok});
        decision_q.push_back(fresh);
        n_samples++;
        if (!in_if.read_ok) begin
          n_failed++;
        end
      end
    end
    in_taken <= rst_ni && in_if.valid && in_if.ready;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.time_count = '0;
    in_if.idle_count = '0;
    in_if.read_ok = 1'b0;
    out_if.ready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    gov_cfg = '{high_thr: HighThrRst, low_thr: LowThrRst, thr_pct: ThrPctRst,
                full_wait: FullWaitRst, thr_wait: ThrWaitRst};
    gov_time = '0;
    gov_idle = '0;
    gov_primed = 1'b0;
    gov_live = 1'b0;
    gov_throttled = 1'b0;
    gen_time = '0;
    gen_idle = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Priming call with a failed read, then the first good read primes the counters.
    queue_sample('1, '1, 1'b0);
    queue_sample(64'd1000, 64'd400, 1'b1);
    queue_delta(64'd1000, 64'd1000);
    queue_delta('0, 64'd5);
    queue_delta(64'd1000, '0);
    queue_delta(64'd100, 64'd90);
    queue_delta(64'd100, 64'd10);
    queue_delta(64'd100, 64'd11);
    queue_delta(64'd1000, 64'd1001);
    queue_sample(rand64(), rand64(), 1'b0);
    queue_delta(64'd3, 64'd1);
    queue_delta('1, ~64'd1);
    queue_sample(~64'd5, ~64'd5, 1'b1);
    queue_delta(64'd100, '0);
    queue_sample('0, '0, 1'b0);
    queue_delta(64'd7, 64'd3);
    queue_delta(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
    queue_delta(64'd1, '0);
    queue_delta(64'd1, 64'd1);
    wait_for_idle();

    for (int phase = 1; phase <= PhaseCount; phase++) begin
      program_phase(phase);
      repeat (ItemsPerPhase) queue_random_sample();
      wait_for_idle();
    end
    repeat (SettleCycles) @(posedge clk_i);

    $display("Run covered %0d samples (%0d failed reads) under %0d register settings,",
             n_samples, n_failed, n_settings);
    $display("with %0d throttle field writes, %0d drains and %0d mismatches.",
             n_writes, n_drains, err_cnt);
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("Timed out with %0d samples waiting and %0d results outstanding.",
             sample_q.size(), decision_q.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
